### rtl/core/rea_pkg.sv
// rea_pkg: shared widths, register map and types for the rotary encoder position block
// no dependencies; imported by every module of the block
package rea_pkg;

    localparam int POS_W   = 16;
    localparam int TIME_W  = 32;
    localparam int STEP_W  = 8;
    localparam int MS_W    = 16;
    localparam int SUM_W   = POS_W + 2;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int IDX_W   = 3;
    localparam int S_DATA_W = ((2 + TIME_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((POS_W + 7) / 8) * 8;
    localparam int M_USER_W = 2;

    localparam logic [IDX_W-1:0] REG_MIN_POS   = 3'd0;
    localparam logic [IDX_W-1:0] REG_MAX_POS   = 3'd1;
    localparam logic [IDX_W-1:0] REG_STEP      = 3'd2;
    localparam logic [IDX_W-1:0] REG_FAST_STEP = 3'd3;
    localparam logic [IDX_W-1:0] REG_WRAP      = 3'd4;
    localparam logic [IDX_W-1:0] REG_INIT_POS  = 3'd5;
    localparam logic [IDX_W-1:0] REG_FAST_WIN  = 3'd6;
    localparam logic [IDX_W-1:0] REG_MAX_LOW   = 3'd7;

    localparam logic signed [POS_W-1:0] MIN_POS_RST   = -16'sd32767;
    localparam logic signed [POS_W-1:0] MAX_POS_RST   = 16'sd32766;
    localparam logic [STEP_W-1:0]       STEP_RST      = 8'd1;
    localparam logic [STEP_W-1:0]       FAST_STEP_RST = 8'd2;
    localparam logic signed [POS_W-1:0] INIT_POS_RST  = '0;
    localparam logic [MS_W-1:0]         FAST_WIN_RST  = 16'd300;
    localparam logic [MS_W-1:0]         MAX_LOW_RST   = 16'd1000;

    typedef struct packed {
        logic signed [POS_W-1:0] min_pos;
        logic signed [POS_W-1:0] max_pos;
        logic [STEP_W-1:0]       step;
        logic [STEP_W-1:0]       fast_step;
        logic                    wrap;
        logic [MS_W-1:0]         fast_win;
        logic [MS_W-1:0]         max_low;
    } cfg_t;

    typedef struct packed {
        logic                    load;
        logic signed [POS_W-1:0] value;
    } pos_load_t;

    typedef struct packed {
        logic signed [POS_W-1:0] position;
        logic                    moved;
        logic                    moved_down;
    } result_t;

endpackage

### rtl/core/rea_cfg.sv
// rea_cfg: apb register file for limits, steps, wrap and timing windows
// depends on rea_pkg; produces the position load strobe on init_position writes
module rea_cfg import rea_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg,
    output pos_load_t         pos_load
);

    cfg_t                    cfg_reg;
    logic signed [POS_W-1:0] init_reg;
    logic                    wr_en;
    logic [IDX_W-1:0]        idx;
    logic signed [POS_W-1:0] wr_pos;

    assign pready = 1'b1;
    assign idx    = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign wr_pos = pwdata[POS_W-1:0];
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_pos   <= MIN_POS_RST;
            cfg_reg.max_pos   <= MAX_POS_RST;
            cfg_reg.step      <= STEP_RST;
            cfg_reg.fast_step <= FAST_STEP_RST;
            cfg_reg.wrap      <= 1'b0;
            cfg_reg.fast_win  <= FAST_WIN_RST;
            cfg_reg.max_low   <= MAX_LOW_RST;
            init_reg          <= INIT_POS_RST;
        end else if (wr_en) begin
            case (idx)
                REG_MIN_POS:   cfg_reg.min_pos   <= wr_pos;
                REG_MAX_POS:   cfg_reg.max_pos   <= wr_pos;
                REG_STEP:      cfg_reg.step      <= pwdata[STEP_W-1:0];
                REG_FAST_STEP: cfg_reg.fast_step <= pwdata[STEP_W-1:0];
                REG_WRAP:      cfg_reg.wrap      <= pwdata[0];
                REG_INIT_POS:  init_reg          <= wr_pos;
                REG_FAST_WIN:  cfg_reg.fast_win  <= pwdata[MS_W-1:0];
                REG_MAX_LOW:   cfg_reg.max_low   <= pwdata[MS_W-1:0];
                default: ;
            endcase
        end
    end

    // out-of-range init falls back to the lower limit
    always_comb begin
        pos_load.load  = wr_en && (idx == REG_INIT_POS);
        pos_load.value = (wr_pos >= cfg_reg.min_pos && wr_pos <= cfg_reg.max_pos) ?
                         wr_pos : cfg_reg.min_pos;
    end

    always_comb begin
        case (idx)
            REG_MIN_POS:   prdata = DATA_W'($unsigned(cfg_reg.min_pos));
            REG_MAX_POS:   prdata = DATA_W'($unsigned(cfg_reg.max_pos));
            REG_STEP:      prdata = DATA_W'(cfg_reg.step);
            REG_FAST_STEP: prdata = DATA_W'(cfg_reg.fast_step);
            REG_WRAP:      prdata = DATA_W'(cfg_reg.wrap);
            REG_INIT_POS:  prdata = DATA_W'($unsigned(init_reg));
            REG_FAST_WIN:  prdata = DATA_W'(cfg_reg.fast_win);
            REG_MAX_LOW:   prdata = DATA_W'(cfg_reg.max_low);
            default:       prdata = '0;
        endcase
    end

endmodule

### rtl/core/rea_upd.sv
// rea_upd: encoder state (arm, captured b, timestamps, position) and its per-event update
// depends on rea_pkg; result is combinational from the current word and state
module rea_upd import rea_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  logic              a_level,
    input  logic              b_level,
    input  logic [TIME_W-1:0] now_ms,
    input  cfg_t              cfg,
    input  pos_load_t         pos_load,
    output result_t           result
);

    logic signed [POS_W-1:0] pos_reg, pos_next;
    logic                    armed_reg, armed_next;
    logic                    bcap_reg, bcap_next;
    logic [TIME_W-1:0]       low_start_reg, low_start_next;
    logic [TIME_W-1:0]       last_move_reg, last_move_next;

    logic [TIME_W-1:0]       low_dur;
    logic [TIME_W-1:0]       since_move;
    logic                    rearm;
    logic                    do_move;
    logic [STEP_W-1:0]       step_max;
    logic [STEP_W-1:0]       step_sel;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] min_w, max_w;
    logic signed [POS_W-1:0] new_pos;

    assign low_dur    = now_ms - low_start_reg;
    assign since_move = now_ms - last_move_reg;
    assign rearm      = !armed_reg || (low_dur > TIME_W'(cfg.max_low));
    assign do_move    = a_level && armed_reg && (low_dur < TIME_W'(cfg.max_low));
    assign step_max   = (cfg.fast_step > cfg.step) ? cfg.fast_step : cfg.step;
    assign step_sel   = (since_move < TIME_W'(cfg.fast_win)) ? step_max : cfg.step;
    assign min_w      = SUM_W'(cfg.min_pos);
    assign max_w      = SUM_W'(cfg.max_pos);

    // upper limit first, then lower, as with crossed limits
    always_comb begin
        if (bcap_reg) begin
            sum = SUM_W'(pos_reg) - $signed({{(SUM_W-STEP_W){1'b0}}, step_sel});
        end else begin
            sum = SUM_W'(pos_reg) + $signed({{(SUM_W-STEP_W){1'b0}}, step_sel});
        end
        if (sum > max_w) begin
            sum = cfg.wrap ? min_w : max_w;
        end
        if (sum < min_w) begin
            sum = cfg.wrap ? max_w : min_w;
        end
        new_pos = sum[POS_W-1:0];
    end

    always_comb begin
        pos_next       = pos_reg;
        armed_next     = armed_reg;
        bcap_next      = bcap_reg;
        low_start_next = low_start_reg;
        last_move_next = last_move_reg;
        if (!a_level) begin
            if (rearm) begin
                armed_next     = 1'b1;
                low_start_next = now_ms;
                bcap_next      = b_level;
            end
        end else if (armed_reg) begin
            armed_next = 1'b0;
            if (do_move) begin
                last_move_next = now_ms;
                pos_next       = new_pos;
            end
        end
    end

    always_comb begin
        result.position   = pos_next;
        result.moved      = (pos_next != pos_reg);
        result.moved_down = (pos_next != pos_reg) && bcap_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= INIT_POS_RST;
            armed_reg     <= 1'b0;
            bcap_reg      <= 1'b0;
            low_start_reg <= '0;
            last_move_reg <= '0;
        end else if (pos_load.load) begin
            pos_reg <= pos_load.value;
        end else if (fire) begin
            pos_reg       <= pos_next;
            armed_reg     <= armed_next;
            bcap_reg      <= bcap_next;
            low_start_reg <= low_start_next;
            last_move_reg <= last_move_next;
        end
    end

endmodule

### rtl/core/rotary_encoder_accel_position.sv
// rotary_encoder_accel_position: input register, state update and result register
// depends on rea_pkg, rea_cfg and rea_upd
//
// usage
//   s_ side takes one encoder channel a change event per word: a level, b level and
//   a millisecond timestamp. m_ side returns one word per event: the position after
//   the event, with moved and moved_down flags in m_tuser.
//   the apb port sets limits, step sizes, wrap mode and the two time windows; a write
//   to init_position loads the position (or the lower limit when out of range).
// pipeline and throughput
//   a result word is valid on the m_ side once its event has passed the input register
//   and the result register, which loads only while empty or being taken. one word
//   per cycle is sustained while m_tready stays high: the state update (arm, clamp,
//   wrap) is combinational between the input register and the result register.
// reset
//   aresetn low clears both valid flags, the arm state and timestamps, sets the
//   position to zero and the registers to their defaults.
// stalls
//   while m_tready is low the result register holds; the input register still takes
//   one more word, after which s_tready drops until the result is taken.
module rotary_encoder_accel_position import rea_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // a_level, b_level, now_ms, zero pad
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // position
    output logic [M_USER_W-1:0] m_tuser,   // moved, moved_down
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    cfg_t              cfg;
    pos_load_t         pos_load;
    result_t           result;

    logic              in_valid_reg;
    logic              in_a_reg;
    logic              in_b_reg;
    logic [TIME_W-1:0] in_now_reg;
    logic              out_valid_reg;
    result_t           out_reg;
    logic              advance;
    logic              fire;

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    rea_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .cfg      (cfg),
        .pos_load (pos_load)
    );

    rea_upd u_upd (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .fire     (fire),
        .a_level  (in_a_reg),
        .b_level  (in_b_reg),
        .now_ms   (in_now_reg),
        .cfg      (cfg),
        .pos_load (pos_load),
        .result   (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_a_reg   <= s_tdata[0];
            in_b_reg   <= s_tdata[1];
            in_now_reg <= s_tdata[TIME_W+1:2];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'($unsigned(out_reg.position));
    assign m_tuser  = {out_reg.moved_down, out_reg.moved};

endmodule

### rtl/core/rea_chk.sv
// rea_chk: port-level assertions for rotary_encoder_accel_position
// depends on rea_pkg; attached to the top level by the bind below
module rea_chk import rea_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic [M_USER_W-1:0] m_tuser
);

    // stalled word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // down flag only with a move
    a_down_moved: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[1] && !m_tuser[0]))
        else $error("moved_down without moved");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a new result follows an accepted event, through the input and result registers
    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && aresetn, 2))
        else $error("result without an accepted event");

endmodule

bind rotary_encoder_accel_position rea_chk u_rea_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
